>>> hdl/cle_pkg.sv
package cle_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int PTR_W     = $clog2(2 * BUF_DEPTH);
    localparam int IDX_W     = $clog2(BUF_DEPTH);

    localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(2 * BUF_DEPTH - 1);
    localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(BUF_DEPTH);
    localparam logic [PTR_W:0]   PTR_MOD   = (PTR_W+1)'(2 * BUF_DEPTH);

    localparam logic [7:0] KEY_DEL    = 8'h7f;
    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_LF     = 8'h0a;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] CNT_MAX    = 8'hff;

    typedef enum logic [3:0] {
        K_IGNORED      = 4'd0,
        K_ECHO         = 4'd1,
        K_ERASE        = 4'd2,
        K_DUMP         = 4'd3,
        K_BYTE         = 4'd4,
        K_LINE_END     = 4'd5,
        K_EOF_CONSUMED = 4'd6,
        K_EOF_KEPT     = 4'd7,
        K_NOT_READY    = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        BSEL_ZERO,
        BSEL_CHAR,
        BSEL_DATA
    } t_bsel;

    typedef enum logic [1:0] {
        CSEL_ZERO,
        CSEL_ONE,
        CSEL_CNT
    } t_csel;

    typedef struct packed {
        logic  load;
        logic  rd_read;
        logic  rd_edit;
        logic  dec_edit;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  store;
        logic  inc_read;
        logic  emit;
        t_kind kind;
        t_bsel bsel;
        t_csel csel;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic is_ctrl_p;
        logic is_ctrl_u;
        logic is_del;
        logic is_zero;
        logic full;
        logic ed_eq_cm;
        logic rd_eq_cm;
        logic data_lf;
        logic data_eod;
        logic first;
        logic out_busy;
    } t_sts;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_MAX) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_MAX : PTR_W'(p - 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        return (a >= b) ? PTR_W'(a - b) : PTR_W'({1'b0, a} + PTR_MOD - {1'b0, b});
    endfunction

    function automatic logic [IDX_W-1:0] slot(input logic [PTR_W-1:0] p);
        return (p >= DEPTH_PTR) ? IDX_W'(p - DEPTH_PTR) : IDX_W'(p);
    endfunction

endpackage

>>> hdl/cle_ctrl.sv
module cle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  cle_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output cle_pkg::t_cmd o_cmd
);
    import cle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_KILL,
        S_KILL_CHK,
        S_KILL_END
    } t_state;

    t_state r_state, n_state;
    t_cmd   c;

    always_comb begin
        c       = '0;
        c.kind  = K_IGNORED;
        c.bsel  = BSEL_ZERO;
        c.csel  = CSEL_ZERO;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.load  = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                    if (i_sts.mode) begin
                        if (i_sts.rd_eq_cm) begin
                            c.emit = 1'b1;
                            c.kind = K_NOT_READY;
                        end else begin
                            c.rd_read = 1'b1;
                            n_state   = S_READ;
                        end
                    end else if (i_sts.is_ctrl_p) begin
                        c.emit = 1'b1;
                        c.kind = K_DUMP;
                    end else if (i_sts.is_ctrl_u) begin
                        c.cnt_clr = 1'b1;
                        n_state   = S_KILL;
                    end else if (i_sts.is_del) begin
                        c.emit = 1'b1;
                        if (i_sts.ed_eq_cm) begin
                            c.kind = K_IGNORED;
                        end else begin
                            c.dec_edit = 1'b1;
                            c.kind     = K_ERASE;
                            c.csel     = CSEL_ONE;
                        end
                    end else if (i_sts.is_zero || i_sts.full) begin
                        c.emit = 1'b1;
                        c.kind = K_IGNORED;
                    end else begin
                        c.store = 1'b1;
                        c.emit  = 1'b1;
                        c.kind  = K_ECHO;
                        c.bsel  = BSEL_CHAR;
                    end
                end
            end
            S_READ: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                    c.emit  = 1'b1;
                    if (i_sts.data_eod) begin
                        if (i_sts.first) begin
                            c.inc_read = 1'b1;
                            c.kind     = K_EOF_CONSUMED;
                        end else begin
                            c.kind = K_EOF_KEPT;
                        end
                    end else begin
                        c.inc_read = 1'b1;
                        c.bsel     = BSEL_DATA;
                        c.kind     = i_sts.data_lf ? K_LINE_END : K_BYTE;
                    end
                end
            end
            S_KILL: begin
                if (i_sts.ed_eq_cm) begin
                    n_state = S_KILL_END;
                end else begin
                    c.rd_edit = 1'b1;
                    n_state   = S_KILL_CHK;
                end
            end
            S_KILL_CHK: begin
                if (i_sts.data_lf) begin
                    n_state = S_KILL_END;
                end else begin
                    c.dec_edit = 1'b1;
                    c.cnt_inc  = 1'b1;
                    n_state    = S_KILL;
                end
            end
            S_KILL_END: begin
                if (!i_sts.out_busy) begin
                    c.emit  = 1'b1;
                    c.kind  = K_ERASE;
                    c.csel  = CSEL_CNT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = c;

endmodule

>>> hdl/cle_dp.sv
module cle_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cle_pkg::t_cmd i_cmd,
    input  logic          i_mode,
    input  logic [7:0]    i_char_in,
    input  logic          i_first_of_read,
    input  logic          i_out_ready,
    output cle_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output logic [3:0]    o_kind,
    output logic [7:0]    o_byte_out,
    output logic [7:0]    o_erase_count,
    output logic          o_line_ready
);
    import cle_pkg::*;

    logic [7:0]       mem [BUF_DEPTH];
    logic             r_mode;
    logic [7:0]       r_char;
    logic             r_first;
    logic [PTR_W-1:0] r_rp, r_cp, r_ep;
    logic [7:0]       r_rdata;
    logic [7:0]       r_cnt;
    logic             r_ovalid;
    logic [3:0]       r_kind;
    logic [7:0]       r_byte;
    logic [7:0]       r_erase;
    logic             r_line;

    logic [7:0]       c_conv;
    logic [PTR_W-1:0] ep_inc;
    logic             commit;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       n_byte;
    logic [7:0]       n_erase;

    assign c_conv = (r_char == KEY_CR) ? KEY_LF : r_char;
    assign ep_inc = ptr_inc(r_ep);
    assign commit = (c_conv == KEY_LF) || (c_conv == KEY_CTRL_D)
                    || (ptr_dist(ep_inc, r_rp) == DEPTH_PTR);
    assign rd_idx = i_cmd.rd_edit ? slot(ptr_dec(r_ep)) : slot(r_rp);

    always_comb begin
        case (i_cmd.bsel)
            BSEL_CHAR: n_byte = c_conv;
            BSEL_DATA: n_byte = r_rdata;
            default:   n_byte = '0;
        endcase
        case (i_cmd.csel)
            CSEL_ONE: n_erase = 8'd1;
            CSEL_CNT: n_erase = r_cnt;
            default:  n_erase = '0;
        endcase
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[slot(r_ep)] <= c_conv;
        end
        if (i_cmd.rd_read || i_cmd.rd_edit) begin
            r_rdata <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_char  <= i_char_in;
            r_first <= i_first_of_read;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc && r_cnt != CNT_MAX) begin
            r_cnt <= r_cnt + 8'd1;
        end
        if (i_cmd.emit) begin
            r_kind  <= i_cmd.kind;
            r_byte  <= n_byte;
            r_erase <= n_erase;
            r_line  <= i_cmd.store && commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_cp     <= '0;
            r_ep     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_ep <= ep_inc;
                if (commit) begin
                    r_cp <= ep_inc;
                end
            end else if (i_cmd.dec_edit) begin
                r_ep <= ptr_dec(r_ep);
            end
            if (i_cmd.inc_read) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.is_ctrl_p = (r_char == KEY_CTRL_P);
        o_sts.is_ctrl_u = (r_char == KEY_CTRL_U);
        o_sts.is_del    = (r_char == KEY_DEL);
        o_sts.is_zero   = (r_char == KEY_NUL);
        o_sts.full      = (ptr_dist(r_ep, r_rp) == DEPTH_PTR);
        o_sts.ed_eq_cm  = (r_ep == r_cp);
        o_sts.rd_eq_cm  = (r_rp == r_cp);
        o_sts.data_lf   = (r_rdata == KEY_LF);
        o_sts.data_eod  = (r_rdata == KEY_CTRL_D);
        o_sts.first     = r_first;
        o_sts.out_busy  = r_ovalid;
    end

    assign o_out_valid   = r_ovalid;
    assign o_kind        = r_kind;
    assign o_byte_out    = r_byte;
    assign o_erase_count = r_erase;
    assign o_line_ready  = r_line;

endmodule

>>> hdl/console_line_editor.sv
// console line editor: canonical terminal line editing over a ring buffer
// input channel (i_in_valid / o_in_ready) takes one word: a received key
// when i_mode is 0, or a request for one byte by the reader when i_mode is 1
// output channel (o_out_valid / i_out_ready) gives exactly one result word
// per input word: kind, echoed or delivered byte, erase count, line flag
// one word is worked at a time; o_in_ready is high only while the
// controller is idle
// plain keys, del, ctrl-p and not-ready reads are accepted in the idle
// state and reach the result register from the decode state; a byte
// read goes through decode and then the read state (registered line
// store read); ctrl-u walks the store back one character at a time
// (read then test) and stops at the commit point or at a newline
// the controller is idle again the cycle after the result is written,
// so it takes the next word only once the last one has its result
// the result sits in an output register, so the next word is accepted
// while a result waits; that word then holds until the register is taken
// reset clears the read, commit and edit pointers and the output valid;
// the line store needs no clearing since no entry is read before written
module console_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_char_in,
    input  logic       i_first_of_read,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic [7:0] o_erase_count,
    output logic       o_line_ready
);
    import cle_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    cle_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_first_of_read (i_first_of_read),
        .i_out_ready     (i_out_ready),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_byte_out      (o_byte_out),
        .o_erase_count   (o_erase_count),
        .o_line_ready    (o_line_ready)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !sts.out_busy)
        else $error("result written over a waiting word");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.store |-> !sts.full)
        else $error("store into a full buffer");

    a_erase_uncommitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.dec_edit |-> !sts.ed_eq_cm)
        else $error("erase past the commit point");

    a_read_committed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.inc_read |-> !sts.rd_eq_cm)
        else $error("read past the commit point");

endmodule

>>> dv/cle_checker.sv
module cle_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_char_in,
    input  logic       i_first_of_read,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] i_kind,
    input  logic [7:0] i_byte_out,
    input  logic [7:0] i_erase_count,
    input  logic       i_line_ready,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int RING = 2 * BUF_DEPTH;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] erased;
        logic       line_done;
    } t_reply;

    logic [7:0] line_ring [BUF_DEPTH];
    int         rd_ptr;
    int         cm_ptr;
    int         ed_ptr;
    t_reply     reply_queue [$];
    int         mismatch_total;
    int         checked_total;

    function automatic int ring_next(input int p);
        return (p + 1) % RING;
    endfunction

    function automatic int ring_back(input int p);
        return (p + RING - 1) % RING;
    endfunction

    function automatic int ring_gap(input int a, input int b);
        return (a + RING - b) % RING;
    endfunction

    function automatic int ring_slot(input int p);
        return p % BUF_DEPTH;
    endfunction

    function automatic t_reply editor_reply(input logic mode, input logic [7:0] key_code,
                                            input logic first);
        t_reply     r;
        int         n;
        logic [7:0] c;
        r.kind      = K_IGNORED;
        r.data      = 8'h00;
        r.erased    = 8'h00;
        r.line_done = 1'b0;
        c           = key_code;
        if (!mode) begin
            if (c == KEY_CTRL_P) begin
                r.kind = K_DUMP;
            end else if (c == KEY_CTRL_U) begin
                n = 0;
                while (ed_ptr != cm_ptr && line_ring[ring_slot(ring_back(ed_ptr))] != KEY_LF) begin
                    ed_ptr = ring_back(ed_ptr);
                    n++;
                end
                r.kind   = K_ERASE;
                r.erased = (n > 255) ? CNT_MAX : 8'(n);
            end else if (c == KEY_DEL) begin
                if (ed_ptr != cm_ptr) begin
                    ed_ptr   = ring_back(ed_ptr);
                    r.kind   = K_ERASE;
                    r.erased = 8'd1;
                end
            end else if (c != KEY_NUL && ring_gap(ed_ptr, rd_ptr) < BUF_DEPTH) begin
                if (c == KEY_CR) begin
                    c = KEY_LF;
                end
                line_ring[ring_slot(ed_ptr)] = c;
                ed_ptr = ring_next(ed_ptr);
                if (c == KEY_LF || c == KEY_CTRL_D || ring_gap(ed_ptr, rd_ptr) == BUF_DEPTH) begin
                    cm_ptr      = ed_ptr;
                    r.line_done = 1'b1;
                end
                r.kind = K_ECHO;
                r.data = c;
            end
        end else if (rd_ptr == cm_ptr) begin
            r.kind = K_NOT_READY;
        end else begin
            c = line_ring[ring_slot(rd_ptr)];
            if (c == KEY_CTRL_D) begin
                if (first) begin
                    rd_ptr = ring_next(rd_ptr);
                    r.kind = K_EOF_CONSUMED;
                end else begin
                    r.kind = K_EOF_KEPT;
                end
            end else begin
                rd_ptr = ring_next(rd_ptr);
                r.kind = (c == KEY_LF) ? K_LINE_END : K_BYTE;
                r.data = c;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_total++;
        if (mismatch_total <= 40) begin
            $display("mismatch at reply %0d: %s is %0d, expected %0d",
                     checked_total, field, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            rd_ptr = 0;
            cm_ptr = 0;
            ed_ptr = 0;
            reply_queue.delete();
            mismatch_total = 0;
            checked_total  = 0;
        end else begin
            // the reply leaving now always belongs to an older word
            if (i_out_valid && i_out_ready) begin
                if (reply_queue.size() == 0) begin
                    report_mismatch("unexpected reply kind", int'(i_kind), -1);
                end else begin
                    want = reply_queue.pop_front();
                    if (i_kind != want.kind)
                        report_mismatch("kind", int'(i_kind), int'(want.kind));
                    if (i_byte_out != want.data)
                        report_mismatch("byte_out", int'(i_byte_out), int'(want.data));
                    if (i_erase_count != want.erased)
                        report_mismatch("erase_count", int'(i_erase_count), int'(want.erased));
                    if (i_line_ready != want.line_done)
                        report_mismatch("line_ready", int'(i_line_ready), int'(want.line_done));
                end
                checked_total++;
            end
            if (i_in_valid && i_in_ready) begin
                reply_queue.push_back(editor_reply(i_mode, i_char_in, i_first_of_read));
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= reply_queue.size();
        o_checked    <= checked_total;
    end

endmodule

>>> dv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int ITEMS       = 1800;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 2 * BUF_DEPTH + 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_mode = 1'b0;
    logic [7:0] i_char_in = 8'h00;
    logic       i_first_of_read = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_kind;
    logic [7:0] o_byte_out;
    logic [7:0] o_erase_count;
    logic       o_line_ready;

    int fail_count;
    int pending;
    int checked;
    int sent_count = 0;
    int word_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;

    console_line_editor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_first_of_read (i_first_of_read),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_byte_out      (o_byte_out),
        .o_erase_count   (o_erase_count),
        .o_line_ready    (o_line_ready)
    );

    cle_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_first_of_read (i_first_of_read),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_kind          (o_kind),
        .i_byte_out      (o_byte_out),
        .i_erase_count   (o_erase_count),
        .i_line_ready    (o_line_ready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic send_word(input logic mode, input logic [7:0] c, input logic first,
                             input bit counted);
        case (sent_count * 4 / ITEMS)
            0: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct    = 58;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 58;
            end
            default: begin
                sender_idle_pct    = 11;
                receiver_stall_pct = 11;
            end
        endcase
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_char_in       <= c;
        i_first_of_read <= first;
        do @(posedge i_clk); while (!o_in_ready);
        word_count++;
        if (counted) sent_count++;
    endtask

    task automatic key_word(input logic [7:0] c, input bit counted = 1'b1);
        send_word(1'b0, c, 1'($urandom_range(0, 1)), counted);
    endtask

    task automatic read_word(input logic first);
        send_word(1'b1, 8'($urandom_range(0, 255)), first, 1'b1);
    endtask

    task automatic type_line();
        int len;
        int r;
        if ($urandom_range(0, 19) == 0) len = $urandom_range(60, 126);
        else len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) key_word(KEY_DEL);
            else if (r < 10) key_word(KEY_CTRL_U);
            else if (r < 12) key_word(KEY_CTRL_P);
            else if (r < 20) key_word(8'($urandom_range(0, 255)));
            else key_word(8'($urandom_range(8'h20, 8'h7e)));
        end
        r = $urandom_range(0, 9);
        if (r < 4) key_word(KEY_CR);
        else if (r < 7) key_word(KEY_LF);
        else if (r < 9) key_word(KEY_CTRL_D);
    endtask

    task automatic read_burst();
        int n;
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            read_word((i == 0) ? 1'b1 : ($urandom_range(0, 9) == 0));
        end
    endtask

    // type past full, then try to edit committed text, then drain
    task automatic fill_ring();
        for (int i = 0; i < BUF_DEPTH + 4; i++) begin
            key_word(8'($urandom_range(8'h20, 8'h7e)), i < BUF_DEPTH);
        end
        key_word(KEY_CTRL_U);
        key_word(KEY_DEL);
        for (int i = 0; i < BUF_DEPTH + 8; i++) begin
            read_word(i == 0);
        end
    endtask

    initial begin
        int pick;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        key_word(KEY_NUL);
        key_word(KEY_DEL);
        key_word(KEY_CTRL_U);
        key_word(KEY_CTRL_P);
        read_word(1'b1);
        read_word(1'b0);
        key_word(8'hff);
        key_word(8'h61);
        key_word(KEY_DEL);
        key_word(8'h01);
        key_word(KEY_CR);
        read_word(1'b1);
        read_word(1'b0);
        read_word(1'b0);
        key_word(KEY_CTRL_D);
        read_word(1'b0);
        read_word(1'b1);
        key_word(8'h78);
        key_word(8'h79);
        key_word(8'h7a);
        key_word(KEY_CTRL_U);
        key_word(8'h80);
        key_word(KEY_LF);
        key_word(KEY_CTRL_U);
        read_word(1'b1);
        read_word(1'b0);

        fill_ring();
        while (sent_count < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) type_line();
            else if (pick < 80) read_burst();
            else if (pick < 81) fill_ring();
            else begin
                repeat ($urandom_range(1, 8)) begin
                    send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b1);
                end
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d words sent through four idle and stall phases, %0d replies checked",
                 word_count, checked);
        $display("covered key echo, erase, line kill, dump, full ring, eof and reads");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cle_pkg.sv
hdl/cle_ctrl.sv
hdl/cle_dp.sv
hdl/console_line_editor.sv
dv/cle_checker.sv
dv/testbench.sv
